// ----- rtl/core/slp_pkg.sv -----
`default_nettype none

package slp_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned TID_W       = 8;
    localparam int unsigned TCNT_W      = 9;
    localparam int unsigned TRIP_W      = DATA_W + 1;
    localparam int unsigned QDIV_STAGES = DATA_W;
    localparam int unsigned TDIV_STAGES = TRIP_W;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [TID_W-1:0]  t_tid;
    typedef logic [TCNT_W-1:0] t_tcnt;
    typedef logic [TRIP_W-1:0] t_trip;

    localparam t_tcnt MAX_THREADS = t_tcnt'(256);

    typedef struct packed {
        t_tid  tid;
        t_word lo;
        t_word up;
        t_word st;
        logic  stat;
        t_tcnt n;
    } t_req;

    typedef struct packed {
        t_req  req;
        logic  empty;
        t_word rem;
        t_word quo;
        t_word dvs;
    } t_qdiv;

    typedef struct packed {
        t_word new_lower;
        t_word new_upper;
        logic  is_last;
        logic  unsupported;
    } t_rsp;

    function automatic t_tcnt clamp_threads(t_tcnt v);
        t_tcnt r;
        if (v == '0) begin
            r = t_tcnt'(1);
        end else if (v > MAX_THREADS) begin
            r = MAX_THREADS;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/slp_in_if.sv -----
`default_nettype none

interface slp_in_if import slp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic        [TID_W-1:0]  thread_index;
    logic signed [DATA_W-1:0] lower_bound;
    logic signed [DATA_W-1:0] upper_bound;
    logic signed [DATA_W-1:0] step;
    logic                     is_static;

    modport source (
        output valid, thread_index, lower_bound, upper_bound, step, is_static,
        input  ready
    );

    modport sink (
        input  valid, thread_index, lower_bound, upper_bound, step, is_static,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/slp_out_if.sv -----
`default_nettype none

interface slp_out_if import slp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] new_lower;
    logic signed [DATA_W-1:0] new_upper;
    logic                     is_last;
    logic                     unsupported;

    modport source (
        output valid, new_lower, new_upper, is_last, unsupported,
        input  ready
    );

    modport sink (
        input  valid, new_lower, new_upper, is_last, unsupported,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/slp_trip.sv -----
`default_nettype none

module slp_trip import slp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_req  i_req,
    output logic       o_vld,
    output t_qdiv      o_div
);

    logic [QDIV_STAGES:0] r_vld;
    t_qdiv                r_st [QDIV_STAGES+1];
    t_qdiv                n_st [QDIV_STAGES+1];
    logic [DATA_W:0]      diff;
    logic                 st_pos;
    logic                 st_zero;
    t_word                mag;

    function automatic t_qdiv div_step(t_qdiv s);
        t_qdiv          r;
        logic [DATA_W:0] t;
        logic [DATA_W:0] d;
        r = s;
        t = {s.rem, s.quo[DATA_W-1]};
        d = t - {1'b0, s.dvs};
        if (t >= {1'b0, s.dvs}) begin
            r.rem = d[DATA_W-1:0];
            r.quo = {s.quo[DATA_W-2:0], 1'b1};
        end else begin
            r.rem = t[DATA_W-1:0];
            r.quo = {s.quo[DATA_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb begin
        st_zero = (i_req.st == '0);
        st_pos  = !i_req.st[DATA_W-1] && !st_zero;
        if (st_pos) begin
            diff = {i_req.up[DATA_W-1], i_req.up} - {i_req.lo[DATA_W-1], i_req.lo};
        end else begin
            diff = {i_req.lo[DATA_W-1], i_req.lo} - {i_req.up[DATA_W-1], i_req.up};
        end
        mag = i_req.st[DATA_W-1] ? (~i_req.st + t_word'(1)) : i_req.st;

        n_st[0].req   = i_req;
        n_st[0].empty = st_zero || diff[DATA_W];
        n_st[0].rem   = '0;
        n_st[0].quo   = diff[DATA_W-1:0];
        n_st[0].dvs   = st_zero ? t_word'(1) : mag;
        for (int k = 1; k <= QDIV_STAGES; k++) begin
            n_st[k] = div_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QDIV_STAGES-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= QDIV_STAGES; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_vld = r_vld[QDIV_STAGES];
    assign o_div = r_st[QDIV_STAGES];

endmodule

`default_nettype wire

// ----- rtl/core/slp_split.sv -----
`default_nettype none

module slp_split import slp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_qdiv i_div,
    output logic       o_vld,
    output t_rsp       o_rsp
);

    typedef struct packed {
        t_req  req;
        t_tcnt rem;
        t_trip quo;
    } t_sdiv;

    typedef struct packed {
        t_req  req;
        t_word prod;
        t_tid  minv;
        t_word cm1;
        logic  busy;
        logic  last;
    } t_sa;

    typedef struct packed {
        t_req  req;
        t_word start;
        t_word stop;
        logic  busy;
        logic  last;
    } t_sb;

    typedef struct packed {
        t_req  req;
        t_word plo;
        t_word pup;
        logic  busy;
        logic  last;
    } t_sc;

    logic [TDIV_STAGES:0] r_dvld;
    t_sdiv                r_dst [TDIV_STAGES+1];
    t_sdiv                n_dst [TDIV_STAGES+1];
    logic                 r_vld_a;
    logic                 r_vld_b;
    logic                 r_vld_c;
    logic                 r_vld_d;
    t_sa                  r_a;
    t_sa                  n_a;
    t_sb                  r_b;
    t_sb                  n_b;
    t_sc                  r_c;
    t_sc                  n_c;
    t_rsp                 r_d;
    t_rsp                 n_d;
    t_sdiv                dq;
    t_tcnt                tid9;
    t_tcnt                nxt9;
    logic                 in_team;
    logic                 has_extra;
    logic                 chunk_zero;

    function automatic t_sdiv div_step(t_sdiv s);
        t_sdiv           r;
        logic [TCNT_W:0] t;
        logic [TCNT_W:0] d;
        r = s;
        t = {s.rem, s.quo[TRIP_W-1]};
        d = t - {1'b0, s.req.n};
        if (t >= {1'b0, s.req.n}) begin
            r.rem = d[TCNT_W-1:0];
            r.quo = {s.quo[TRIP_W-2:0], 1'b1};
        end else begin
            r.rem = t[TCNT_W-1:0];
            r.quo = {s.quo[TRIP_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb begin
        n_dst[0].req = i_div.req;
        n_dst[0].rem = '0;
        n_dst[0].quo = i_div.empty ? '0 : ({1'b0, i_div.quo} + t_trip'(1));
        for (int k = 1; k <= TDIV_STAGES; k++) begin
            n_dst[k] = div_step(r_dst[k-1]);
        end
    end

    always_comb begin
        dq         = r_dst[TDIV_STAGES];
        tid9       = {1'b0, dq.req.tid};
        nxt9       = tid9 + t_tcnt'(1);
        in_team    = tid9 < dq.req.n;
        has_extra  = tid9 < dq.rem;
        chunk_zero = (dq.quo == '0);

        n_a.req  = dq.req;
        n_a.prod = {{(DATA_W-TID_W){1'b0}}, dq.req.tid} * dq.quo[DATA_W-1:0];
        n_a.minv = has_extra ? dq.req.tid : dq.rem[TID_W-1:0];
        n_a.cm1  = has_extra ? dq.quo[DATA_W-1:0] : (dq.quo[DATA_W-1:0] - t_word'(1));
        n_a.busy = in_team && (!chunk_zero || has_extra);
        n_a.last = in_team && (!chunk_zero || has_extra)
                   && ((nxt9 == dq.req.n) || (chunk_zero && (nxt9 == dq.rem)));

        n_b.req   = r_a.req;
        n_b.start = r_a.prod + {{(DATA_W-TID_W){1'b0}}, r_a.minv};
        n_b.stop  = r_a.prod + {{(DATA_W-TID_W){1'b0}}, r_a.minv} + r_a.cm1;
        n_b.busy  = r_a.busy;
        n_b.last  = r_a.last;

        n_c.req  = r_b.req;
        n_c.plo  = r_b.start * r_b.req.st;
        n_c.pup  = r_b.stop * r_b.req.st;
        n_c.busy = r_b.busy;
        n_c.last = r_b.last;

        n_d.unsupported = !r_c.req.stat;
        n_d.is_last     = r_c.req.stat && r_c.last;
        if (!r_c.req.stat) begin
            n_d.new_lower = r_c.req.lo;
            n_d.new_upper = r_c.req.up;
        end else if (!r_c.busy) begin
            n_d.new_lower = r_c.req.up + r_c.req.st;
            n_d.new_upper = r_c.req.up;
        end else begin
            n_d.new_lower = r_c.req.lo + r_c.plo;
            n_d.new_upper = r_c.req.lo + r_c.pup;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld  <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else if (i_en) begin
            r_dvld  <= {r_dvld[TDIV_STAGES-1:0], i_vld};
            r_vld_a <= r_dvld[TDIV_STAGES];
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
            r_vld_d <= r_vld_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= TDIV_STAGES; k++) begin
                r_dst[k] <= n_dst[k];
            end
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld_d;
    assign o_rsp = r_d;

endmodule

`default_nettype wire

// ----- rtl/core/static_loop_partition_unit.sv -----
// Throughput: one beat per cycle; every stage, including the 32 stages of the
// trip-count divider and the 33 stages of the thread-share divider, moves together.
// A held result stalls the whole pipeline until it is taken.
// Reset is synchronous and active low; it empties the pipeline and sets the
// thread count to one.
`default_nettype none

module static_loop_partition_unit import slp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [TCNT_W-1:0] i_cfg_wdata,
    slp_in_if.sink                 i_req,
    slp_out_if.source              o_rsp
);

    t_tcnt r_thread_count;
    logic  en;
    t_req  req;
    logic  trip_vld;
    t_qdiv trip_div;
    logic  split_vld;
    t_rsp  split_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thread_count <= t_tcnt'(1);
        end else if (i_cfg_we) begin
            r_thread_count <= i_cfg_wdata;
        end
    end

    assign en          = !split_vld || o_rsp.ready;
    assign i_req.ready = en;

    always_comb begin
        req.tid  = i_req.thread_index;
        req.lo   = i_req.lower_bound;
        req.up   = i_req.upper_bound;
        req.st   = i_req.step;
        req.stat = i_req.is_static;
        req.n    = clamp_threads(r_thread_count);
    end

    slp_trip u_trip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_req.valid),
        .i_req   (req),
        .o_vld   (trip_vld),
        .o_div   (trip_div)
    );

    slp_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (trip_vld),
        .i_div   (trip_div),
        .o_vld   (split_vld),
        .o_rsp   (split_rsp)
    );

    assign o_rsp.valid       = split_vld;
    assign o_rsp.new_lower   = split_rsp.new_lower;
    assign o_rsp.new_upper   = split_rsp.new_upper;
    assign o_rsp.is_last     = split_rsp.is_last;
    assign o_rsp.unsupported = split_rsp.unsupported;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

module tb;
    import slp_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES  = 100;
    localparam int unsigned PHASE_ITEMS   = 100;
    localparam int unsigned PHASES        = 13;
    localparam int unsigned IDLE_PERCENT  = 37;

    typedef struct packed {
        t_tcnt team;
        t_tid  tid;
        t_word lo;
        t_word up;
        t_word st;
        logic  stat;
        logic  typed;
        t_rsp  want;
    } t_plan_row;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_tcnt i_cfg_wdata;

    slp_in_if  req_if ();
    slp_out_if rsp_if ();

    static_loop_partition_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    t_rsp        pending_shares [$];
    t_plan_row   plan [$];
    t_tcnt       team_size = t_tcnt'(1);
    int unsigned src_idle  = IDLE_PERCENT;
    int unsigned sink_idle = IDLE_PERCENT;
    int unsigned cycle_count = 0;
    logic        rsp_held = 1'b0;
    logic        failed = 1'b0;
    event        rsp_hold_go;

    t_tcnt phase_team [11] = '{9'd1, 9'd0, 9'd256, 9'd511, 9'd2, 9'd3, 9'd5, 9'd8,
                               9'd64, 9'd257, 9'd100};

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Works out the block of iterations that one thread receives.
    function automatic t_rsp share_of_thread(t_tid tid, t_word lo, t_word up, t_word st,
                                             logic stat, t_tcnt team);
        longint lo_v, up_v, st_v, span;
        longint unsigned n, trip, mag, chunk, extras, start, count;
        t_rsp r;
        lo_v = longint'($signed(lo));
        up_v = longint'($signed(up));
        st_v = longint'($signed(st));
        n = (team == '0) ? 1 : ((team > MAX_THREADS) ? MAX_THREADS : team);
        r = '0;
        if (!stat) begin
            r.new_lower   = lo;
            r.new_upper   = up;
            r.unsupported = 1'b1;
            return r;
        end
        trip = 0;
        if (st_v != 0) begin
            span = (st_v > 0) ? up_v - lo_v : lo_v - up_v;
            mag  = (st_v > 0) ? st_v : -st_v;
            if (span >= 0) begin
                trip = longint'(span) / mag + 1;
            end
        end
        chunk  = trip / n;
        extras = trip % n;
        if (tid >= n) begin
            count = 0;
            start = 0;
        end else if (tid < extras) begin
            count = chunk + 1;
            start = tid * (chunk + 1);
        end else begin
            count = chunk;
            start = extras * (chunk + 1) + (tid - extras) * chunk;
        end
        if (count == 0) begin
            r.new_lower = up + st;
            r.new_upper = up;
            return r;
        end
        r.new_lower = t_word'(lo + start * st);
        r.new_upper = t_word'(lo + (start + count - 1) * st);
        r.is_last   = (start + count == trip);
        return r;
    endfunction

    function automatic void plan_row(t_tcnt team, t_tid tid, t_word lo, t_word up, t_word st,
                                     logic stat, logic typed, t_rsp want);
        plan.push_back('{team, tid, lo, up, st, stat, typed, want});
    endfunction

    task automatic offer(t_tid tid, t_word lo, t_word up, t_word st, logic stat, t_rsp want);
        while ($urandom_range(99) < src_idle) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.thread_index <= tid;
        req_if.lower_bound  <= lo;
        req_if.upper_bound  <= up;
        req_if.step         <= st;
        req_if.is_static    <= stat;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_shares.push_back(want);
        @(negedge i_clk);
    endtask

    // The team size may only change once every outstanding beat has come back.
    task automatic set_team(t_tcnt team);
        req_if.valid <= 1'b0;
        while (pending_shares.size() != 0) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= team;
        @(negedge i_clk);
        i_cfg_we  <= 1'b0;
        team_size = team;
    endtask

    task automatic random_request();
        int unsigned n, trip, mag, off;
        t_tid  tid;
        t_word lo, up, st;
        logic  stat;
        logic  down;
        n = (team_size == '0) ? 1 : ((team_size > MAX_THREADS) ? MAX_THREADS : team_size);
        tid  = ($urandom_range(7) == 0) ? t_tid'($urandom) : t_tid'($urandom_range(n - 1));
        stat = ($urandom_range(15) != 0);
        case ($urandom_range(9))
            0: begin
                lo = $urandom;
                up = $urandom;
                st = $urandom;
            end
            1: begin
                lo = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                       : 32'h7FFF_FFFF - $urandom_range(3);
                up = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                       : 32'h7FFF_FFFF - $urandom_range(3);
                case ($urandom_range(3))
                    0: st = 32'd1;
                    1: st = 32'hFFFF_FFFF;
                    2: st = 32'h8000_0000;
                    default: st = 32'h7FFF_FFFF;
                endcase
            end
            2: begin
                lo = $urandom;
                up = $urandom;
                st = '0;
            end
            default: begin
                mag  = ($urandom_range(3) == 0) ? $urandom_range(1, 100000) : $urandom_range(1, 9);
                down = $urandom_range(1);
                st   = down ? t_word'(-mag) : t_word'(mag);
                trip = $urandom_range(3 * n + 2);
                lo   = $urandom_range(1) ? t_word'($urandom)
                                         : t_word'($urandom_range(2000)) - 32'd1000;
                if (trip == 0) begin
                    off = 1 + $urandom_range(50);
                    up  = down ? lo + off : lo - off;
                end else begin
                    off = $urandom_range(mag - 1);
                    up  = lo + t_word'((trip - 1) * st) + (down ? t_word'(-off) : t_word'(off));
                end
            end
        endcase
        offer(tid, lo, up, st, stat, share_of_thread(tid, lo, up, st, stat, team_size));
    endtask

    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready <= !rsp_held && ($urandom_range(99) >= sink_idle);
        end
    end

    initial begin
        forever begin
            @(rsp_hold_go);
            @(posedge i_clk);
            rsp_held = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rsp_held = 1'b0;
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_shares.size() == 0) begin
                $error("result beat with no request outstanding");
                failed = 1'b1;
            end else begin
                want = pending_shares.pop_front();
                if (rsp_if.new_lower !== want.new_lower) begin
                    $error("new_lower: expected %h, got %h", want.new_lower, rsp_if.new_lower);
                    failed = 1'b1;
                end
                if (rsp_if.new_upper !== want.new_upper) begin
                    $error("new_upper: expected %h, got %h", want.new_upper, rsp_if.new_upper);
                    failed = 1'b1;
                end
                if (rsp_if.is_last !== want.is_last) begin
                    $error("is_last: expected %b, got %b", want.is_last, rsp_if.is_last);
                    failed = 1'b1;
                end
                if (rsp_if.unsupported !== want.unsupported) begin
                    $error("unsupported: expected %b, got %b", want.unsupported,
                           rsp_if.unsupported);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("static_loop_partition_unit test failed");
        $finish;
    end

    initial begin
        t_tcnt team;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        req_if.valid        = 1'b0;
        req_if.thread_index = '0;
        req_if.lower_bound  = '0;
        req_if.upper_bound  = '0;
        req_if.step         = '0;
        req_if.is_static    = 1'b0;

        plan_row(9'd1, 8'd0, 32'd0, 32'd9, 32'd1, 1'b1, 1'b1, t_rsp'{32'd0, 32'd9, 1'b1, 1'b0});
        plan_row(9'd1, 8'd0, -32'sd5, 32'd100, 32'd3, 1'b0, 1'b1,
                 t_rsp'{-32'sd5, 32'd100, 1'b0, 1'b1});
        plan_row(9'd1, 8'd0, 32'd3, 32'd7, 32'd0, 1'b1, 1'b1, t_rsp'{32'd7, 32'd7, 1'b0, 1'b0});
        plan_row(9'd1, 8'd0, 32'd5, 32'd0, 32'd2, 1'b1, 1'b1, t_rsp'{32'd2, 32'd0, 1'b0, 1'b0});
        plan_row(9'd1, 8'd0, 32'd0, 32'd5, -32'sd1, 1'b1, 1'b1,
                 t_rsp'{32'd4, 32'd5, 1'b0, 1'b0});
        plan_row(9'd1, 8'd1, 32'd0, 32'd9, 32'd1, 1'b1, 1'b1, t_rsp'{32'd10, 32'd9, 1'b0, 1'b0});
        plan_row(9'd1, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 1'b1, 1'b1,
                 t_rsp'{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0});
        plan_row(9'd1, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, '0);
        plan_row(9'd1, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
                 t_rsp'{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, 1'b0});
        for (int t = 0; t < 5; t++) begin
            plan_row(9'd4, t_tid'(t), 32'd0, 32'd9, 32'd1, 1'b1, 1'b0, '0);
        end
        plan_row(9'd8, 8'd0, 32'd0, 32'd4, 32'd2, 1'b1, 1'b0, '0);
        plan_row(9'd8, 8'd2, 32'd0, 32'd4, 32'd2, 1'b1, 1'b0, '0);
        plan_row(9'd8, 8'd3, 32'd0, 32'd4, 32'd2, 1'b1, 1'b0, '0);
        plan_row(9'd0, 8'd0, 32'd0, 32'd9, 32'd1, 1'b1, 1'b1, t_rsp'{32'd0, 32'd9, 1'b1, 1'b0});
        plan_row(9'd0, 8'd1, 32'd0, 32'd9, 32'd1, 1'b1, 1'b1, t_rsp'{32'd10, 32'd9, 1'b0, 1'b0});
        plan_row(9'd511, 8'd255, 32'd0, 32'd255, 32'd1, 1'b1, 1'b1,
                 t_rsp'{32'd255, 32'd255, 1'b1, 1'b0});
        plan_row(9'd511, 8'd100, 32'd1000, -32'sd1000, -32'sd7, 1'b1, 1'b0, '0);
        plan_row(9'd256, 8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, '0);
        plan_row(9'd256, 8'd255, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1,
                 t_rsp'{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1});

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].team != team_size) begin
                set_team(plan[i].team);
            end
            offer(plan[i].tid, plan[i].lo, plan[i].up, plan[i].st, plan[i].stat,
                  plan[i].typed ? plan[i].want
                                : share_of_thread(plan[i].tid, plan[i].lo, plan[i].up,
                                                  plan[i].st, plan[i].stat, team_size));
        end

        for (int p = 0; p < PHASES; p++) begin
            team = (p < 11) ? phase_team[p] : t_tcnt'($urandom_range(1, 511));
            set_team(team);
            src_idle  = (p == 4) ? 0 : IDLE_PERCENT;
            sink_idle = (p == 4) ? 0 : IDLE_PERCENT;
            // The receiver stops taking beats for a while so that the pipeline backs up.
            if (p == 7) begin
                -> rsp_hold_go;
            end
            repeat (PHASE_ITEMS) random_request();
        end

        req_if.valid <= 1'b0;
        while (pending_shares.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (!failed) begin
            $display("static_loop_partition_unit test passed");
        end else begin
            $display("static_loop_partition_unit test failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
